@@ hw/rtl/decimal_thousands_formatter_core_macros.svh @@
// Assertion macros for the decimal thousands formatter.
// Define ASSERT_OFF to compile the checks out.
`ifndef DECIMAL_THOUSANDS_FORMATTER_CORE_MACROS_SVH
`define DECIMAL_THOUSANDS_FORMATTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define DTF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition at one edge implies a condition at the next edge.
`define DTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DTF_ASSERT(lbl, clk, rst_n, prop)
`define DTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/dtf_pkg.sv @@
// ----------------------------------------------------------------------------
// dtf_pkg
// Types and constants shared by the decimal thousands formatter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

  localparam logic [7:0] CHAR_SEP   = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'

  localparam int unsigned NUM_DIGITS = 10;   // digits of the largest positive input
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned GROUP_LEN = 3;
  localparam int unsigned VAL_W = 31;        // magnitude bits of a positive input
  localparam int unsigned TEXT_W = 4;        // grouped text is at most 13 characters

  // floor(v / 10) = (v * RECIP) >> RECIP_SHIFT for every v below 2^32
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [0:0] CFG_FIELD_WIDTH = 1'b0;
  localparam logic [0:0] CFG_FILL_CHAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } dtf_state_t;

  typedef struct packed {
    logic load;   // take a new number
    logic conv;   // extract one digit
    logic size;   // compute grouped length, pad and overflow
    logic emit;   // load one character into the output register
  } dtf_cmd_t;

  typedef struct packed {
    logic conv_done;  // digit extracted this cycle is the most significant
    logic bad;        // request is invalid: a single empty result follows
    logic last;       // character at the emit point is the final one
    logic out_free;   // output register can take a character
  } dtf_sts_t;

  // Number of separator characters for a digit count of one to ten.
  function automatic logic [1:0] sep_count(input logic [DIGIT_IDX_W:0] nd);
    logic [1:0] s;
    s = 2'd0;
    if (nd > 5'(GROUP_LEN)) s = 2'd1;
    if (nd > 5'(2 * GROUP_LEN)) s = 2'd2;
    if (nd > 5'(3 * GROUP_LEN)) s = 2'd3;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/decimal_thousands_formatter_core.sv @@
// ----------------------------------------------------------------------------
// decimal_thousands_formatter_core
// Formats a positive integer as a right-justified, dot-grouped decimal field.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_number) takes one signed 32-bit
//   number per transfer. Output channel (out_valid/out_stall) returns one
//   character per transfer, left to right, with out_is_last on the final one.
//   An invalid request (number not positive, zero field width, or a fill
//   character that is a digit, '+' or '-') returns one transfer with
//   out_char 0, out_is_last 1 and out_is_empty 1.
//   Configuration: cfg_we with cfg_index 0 sets the field width, 1 sets the
//   fill character; write only while no number is in flight.
// Timing:
//   After the input transfer the digit loop extracts one digit a cycle by
//   reciprocal-multiply divide by ten, then a sizing step sizes the field
//   (an invalid request skips both), then one character enters the output
//   register per cycle while out_stall does not hold it. One number is in
//   work at a time; in_stall is high from acceptance until the last
//   character is loaded into the output register.
// Reset: rst_n (synchronous, active low) clears the sequencer and the output
//   valid, sets field width 16 and fill character space.
// Stall: out_stall holds the current character; emission pauses until it
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_thousands_formatter_core_macros.svh"

module decimal_thousands_formatter_core #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [0:0]         cfg_index,
  input  wire  [7:0]         cfg_wdata,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [31:0] in_number,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [7:0]         out_char,
  output logic               out_is_last,
  output logic               out_is_empty
);

  dtf_pkg::dtf_cmd_t cmd;
  dtf_pkg::dtf_sts_t sts;

  // Sequencer: drives the datapath one step at a time.
  dtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: settings, digit store, text lookup and output register.
  dtf_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_is_last  (out_is_last),
    .out_is_empty (out_is_empty),
    .cmd          (cmd),
    .sts          (sts)
  );

  // An empty result is a single, final, zero character.
  `DTF_ASSERT(a_empty_single, clk, rst_n, !(out_valid && out_is_empty) || (out_is_last && out_char == 8'd0))
  // After an input transfer the block holds off the next number.
  `DTF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // The sequencer never issues two steps at once.
  `DTF_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.load, cmd.conv, cmd.size, cmd.emit}))

endmodule

`default_nettype wire

@@ hw/rtl/dtf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtf_ctrl
// Sequencer: accept, digit conversion, sizing, character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire dtf_pkg::dtf_sts_t sts,
  output dtf_pkg::dtf_cmd_t cmd
);

  dtf_pkg::dtf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dtf_pkg::ST_CONV;
      end
      dtf_pkg::ST_CONV: begin
        if (sts.bad) state_nxt = dtf_pkg::ST_EMIT;
        else if (sts.conv_done) state_nxt = dtf_pkg::ST_SIZE;
      end
      dtf_pkg::ST_SIZE: begin
        state_nxt = dtf_pkg::ST_EMIT;
      end
      dtf_pkg::ST_EMIT: begin
        if (sts.out_free && sts.last) state_nxt = dtf_pkg::ST_IDLE;
      end
      default: state_nxt = dtf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      dtf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      dtf_pkg::ST_CONV: begin
        cmd.conv = !sts.bad;
      end
      dtf_pkg::ST_SIZE: begin
        cmd.size = 1'b1;
      end
      dtf_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/dtf_datapath.sv @@
// ----------------------------------------------------------------------------
// dtf_datapath
// Settings, digit extraction, grouped text lookup and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_datapath #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire  [0:0]        cfg_index,
  input  wire  [7:0]        cfg_wdata,
  input  wire  signed [31:0] in_number,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [7:0]        out_char,
  output logic              out_is_last,
  output logic              out_is_empty,
  input  wire dtf_pkg::dtf_cmd_t cmd,
  output dtf_pkg::dtf_sts_t sts
);

  localparam int unsigned CntW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW   = dtf_pkg::DIGIT_IDX_W;
  localparam int unsigned TW   = dtf_pkg::TEXT_W;
  localparam int unsigned VW   = dtf_pkg::VAL_W;

  logic [6:0]        field_width_r;
  logic [7:0]        fill_char_r;
  logic [VW-1:0]     val_r;
  logic [3:0]        digits_r [dtf_pkg::NUM_DIGITS];
  logic [DW:0]       nd_r;
  logic [TW-1:0]     need_r;
  logic [CntW-1:0]   pad_r;
  logic              ovf_r;
  logic              bad_r;
  logic [CntW-1:0]   k_r;
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_last_r;
  logic              out_empty_r;

  // Field width saturated to the largest supported field.
  logic [CntW-1:0] width_sat;
  assign width_sat = (field_width_r > 7'(MAX_WIDTH)) ? CntW'(MAX_WIDTH)
                                                     : CntW'(field_width_r);

  logic fill_bad;
  assign fill_bad = (fill_char_r >= dtf_pkg::CHAR_ZERO && fill_char_r <= dtf_pkg::CHAR_NINE) ||
                    fill_char_r == dtf_pkg::CHAR_PLUS || fill_char_r == dtf_pkg::CHAR_MINUS;

  logic in_bad;
  assign in_bad = in_number[31] || (in_number == 32'sd0) || (field_width_r == 7'd0) || fill_bad;

  // One decimal digit per cycle by reciprocal multiply.
  logic [63:0]   prod;
  logic [VW-1:0] quot;
  logic [VW-1:0] rem_full;
  assign prod     = 64'(val_r) * 64'(dtf_pkg::DIV10_RECIP);
  assign quot     = VW'(prod >> dtf_pkg::RECIP_SHIFT);
  assign rem_full = val_r - (quot << 3) - (quot << 1);

  logic [TW-1:0] need_calc;
  assign need_calc = TW'(nd_r) + TW'(dtf_pkg::sep_count(nd_r));

  // Character at emit position k_r.
  logic [TW-1:0] text_pos;
  logic [TW-1:0] rpos;
  logic [DW-1:0] dig_idx;
  logic [7:0]    char_sel;
  assign text_pos = TW'(k_r - pad_r);
  assign rpos     = need_r - 4'd1 - text_pos;
  assign dig_idx  = DW'(rpos - (rpos >> 2));

  always_comb begin
    if (bad_r) begin
      char_sel = 8'd0;
    end else if (ovf_r || k_r < pad_r) begin
      char_sel = fill_char_r;
    end else if (rpos[1:0] == 2'd3) begin
      char_sel = dtf_pkg::CHAR_SEP;
    end else begin
      char_sel = dtf_pkg::CHAR_ZERO + 8'(digits_r[dig_idx]);
    end
  end

  logic last_sel;
  assign last_sel = bad_r || (k_r == width_sat - CntW'(1));

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= 7'd16;
      fill_char_r   <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtf_pkg::CFG_FIELD_WIDTH: field_width_r <= cfg_wdata[6:0];
        dtf_pkg::CFG_FILL_CHAR:   fill_char_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload and working registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_number[VW-1:0];
      bad_r <= in_bad;
      nd_r  <= '0;
      k_r   <= '0;
    end
    if (cmd.conv) begin
      digits_r[nd_r[DW-1:0]] <= rem_full[3:0];
      nd_r  <= nd_r + (DW+1)'(1);
      val_r <= quot;
    end
    if (cmd.size) begin
      need_r <= need_calc;
      ovf_r  <= 8'(width_sat) < 8'(need_calc);
      pad_r  <= width_sat - CntW'(need_calc);
    end
    if (cmd.emit) begin
      out_char_r  <= char_sel;
      out_last_r  <= last_sel;
      out_empty_r <= bad_r;
      k_r         <= k_r + CntW'(1);
    end
  end

  assign sts.conv_done = (quot == '0);
  assign sts.bad       = bad_r;
  assign sts.last      = last_sel;
  assign sts.out_free  = out_free;

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_is_last  = out_last_r;
  assign out_is_empty = out_empty_r;

endmodule

`default_nettype wire
